/* src/mexp_pkg.sv */
// Shared constants for the modular exponentiation core.
package mexp_pkg;

  // Width of the message, exponent, modulus and result words on the ports.
  localparam int unsigned DataWidth = 32;

  // Default width of the arithmetic datapath.
  localparam int unsigned OperandWidthDef = 32;

endpackage

/* src/modular_exponentiation_core.sv */
// Modular exponentiation core: result = message^exponent mod modulus, square and multiply.
//
// The core takes one word at a time on the slave stream and returns one result word
// on the master stream. A word is raised to its exponent modulo the modulus register
// by right-to-left square-and-multiply. All modular products go through one shared
// bit-serial multiplier that handles one multiplier bit per cycle. A word costs one product
// to reduce the message, then for each exponent bit up to the highest set bit one pass
// through the sequencing state, one square and one extra product per set bit. The next
// word can be taken only once the previous result has gone to the output register. An
// exponent of zero needs only the reduction product, and a modulus below two skips the
// arithmetic and returns zero. s_axis_tready is high only while the core is idle; a
// finished result sits in the output register until taken, and the next word may be
// accepted meanwhile. The user must write the modulus through the cfg port only while
// no word is in flight; the core does not enforce this. Operand bits above OPERAND_WIDTH
// are ignored.
module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write channel: modulus
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [DataWidth-1:0]   cfg_data_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [2*DataWidth-1:0] s_axis_tdata,  // [31:0] message_value, [63:32] exponent
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [DataWidth-1:0]   m_axis_tdata   // [31:0] result_value
);

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned ExtW = (W > DataWidth) ? W : DataWidth;
  localparam int unsigned CntW = $clog2(W);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRed  = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StSqr  = 3'd3;
  localparam logic [2:0] StNext = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  localparam logic [W-1:0] One = W'(1);

  // (a + b) mod m for a, b < m
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W-1:0] gap;
    gap = m - b;
    if (a >= gap) begin
      return a - gap;
    end
    return a + b;
  endfunction

  logic [2:0]           state_q, state_d;
  logic [DataWidth-1:0] modulus_q;
  logic [W-1:0]         base_q, base_d;
  logic [W-1:0]         res_q, res_d;
  logic [W-1:0]         exp_q, exp_d;
  logic [W-1:0]         op_a_q, op_a_d;
  logic [W-1:0]         op_b_q, op_b_d;
  logic [W-1:0]         acc_q, acc_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [DataWidth-1:0] out_data_q, out_data_d;

  logic [ExtW-1:0] mod_ext, msg_ext, exp_ext, res_ext;
  logic [W-1:0]    mod_w, msg_w, exp_w;
  logic [W-1:0]    dbl, step;
  logic            in_fire, mult_busy, out_free;

  assign mod_ext = ExtW'(modulus_q);
  assign msg_ext = ExtW'(s_axis_tdata[DataWidth-1:0]);
  assign exp_ext = ExtW'(s_axis_tdata[2*DataWidth-1:DataWidth]);
  assign mod_w   = mod_ext[W-1:0];
  assign msg_w   = msg_ext[W-1:0];
  assign exp_w   = exp_ext[W-1:0];
  assign res_ext = ExtW'(res_q);

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  // one multiplier bit per cycle: double, then add the multiplicand if the bit is set
  assign dbl  = add_mod(acc_q, acc_q, mod_w);
  assign step = op_b_q[W-1] ? add_mod(dbl, op_a_q, mod_w) : dbl;
  assign mult_busy = (state_q == StRed) || (state_q == StMul) || (state_q == StSqr);

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    res_d       = res_q;
    exp_d       = exp_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (mult_busy) begin
      acc_d  = step;
      op_b_d = op_b_q << 1;
      cnt_d  = cnt_q - CntW'(1);
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          exp_d  = exp_w;
          res_d  = One;
          // base mod m is the product 1 * base
          op_a_d = One;
          op_b_d = msg_w;
          acc_d  = '0;
          cnt_d  = CntW'(W - 1);
          if (mod_w < W'(2)) begin
            res_d   = '0;
            state_d = StDone;
          end else begin
            state_d = StRed;
          end
        end
      end
      StRed: begin
        if (cnt_q == '0) begin
          base_d  = step;
          state_d = StNext;
        end
      end
      StNext: begin
        acc_d = '0;
        cnt_d = CntW'(W - 1);
        if (exp_q == '0) begin
          state_d = StDone;
        end else if (exp_q[0]) begin
          op_a_d  = base_q;
          op_b_d  = res_q;
          state_d = StMul;
        end else begin
          op_a_d  = base_q;
          op_b_d  = base_q;
          state_d = StSqr;
        end
      end
      StMul: begin
        if (cnt_q == '0) begin
          res_d   = step;
          op_a_d  = base_q;
          op_b_d  = base_q;
          acc_d   = '0;
          cnt_d   = CntW'(W - 1);
          state_d = StSqr;
        end
      end
      StSqr: begin
        if (cnt_q == '0) begin
          base_d  = step;
          exp_d   = exp_q >> 1;
          state_d = StNext;
        end
      end
      StDone: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_ext[DataWidth-1:0];
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      modulus_q   <= DataWidth'(2);
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        modulus_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    res_q      <= res_d;
    exp_q      <= exp_d;
    op_a_q     <= op_a_d;
    op_b_q     <= op_b_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

endmodule

/* sim/tb.sv */
// Self-checking testbench for the modular exponentiation core.
module tb;
  import mexp_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned WordsPerPhase = 40;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [DataWidth-1:0]   cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [2*DataWidth-1:0] s_axis_tdata = '0;  // [31:0] message_value, [63:32] exponent
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [DataWidth-1:0]   m_axis_tdata;       // [31:0] result_value

  logic [DataWidth-1:0] cur_modulus = 32'd2;
  logic [DataWidth-1:0] pending_results[$];
  int unsigned          words_sent = 0;
  int unsigned          results_checked = 0;
  int unsigned          modulus_writes = 0;
  int unsigned          mismatches = 0;
  int unsigned          cycles = 0;
  int unsigned          stall_left = 0;
  bit                   quiet = 1'b0;

  modular_exponentiation_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Right-to-left square and multiply; full 64-bit products never overflow.
  function automatic logic [31:0] mod_power(input logic [31:0] msg, input logic [31:0] e,
                                            input logic [31:0] m);
    logic [63:0] acc;
    logic [63:0] base;
    logic [63:0] m_wide;
    int i;
    if (m < 32'd2) return '0;
    m_wide = {32'd0, m};
    base = {32'd0, msg} % m_wide;
    acc = 64'd1;
    for (i = 0; i < 32; i++) begin
      if (e[i]) acc = (acc * base) % m_wide;
      base = (base * base) % m_wide;
    end
    return acc[31:0];
  endfunction

  // Random back-pressure on the result stream.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if (!quiet && rst_ni && $urandom_range(0, 5) == 0) begin
      m_axis_tready = 1'b0;
      stall_left = $urandom_range(0, 14);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        if (m_axis_tdata !== pending_results[0]) begin
          $display("%0t: result_value mismatch, expected %h, got %h",
                   $time, pending_results[0], m_axis_tdata);
          mismatches++;
        end
        void'(pending_results.pop_front());
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] msg, input logic [31:0] e);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {e, msg};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(mod_power(msg, e, cur_modulus));
    words_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write the modulus only with nothing in flight.
  task automatic write_modulus(input logic [31:0] value);
    drain_results();
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_modulus = value;
    modulus_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_reset_modulus();
    send_word(32'd0, 32'd0);
    send_word(32'd1, 32'd1);
    send_word(32'd3, 32'd5);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_degenerate_moduli();
    write_modulus(32'd0);
    send_word(32'd5, 32'd3);
    send_word(32'd0, 32'd0);
    write_modulus(32'd1);
    send_word(32'd7, 32'd0);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_max_modulus();
    write_modulus(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFE, 32'd2);
    send_word(32'd0, 32'd0);
    send_word(32'd0, 32'd5);
    send_word(32'd12345, 32'd0);
    send_word(32'd2, 32'd31);
    send_word(32'hFFFF_FFFF, 32'd1);
  endtask

  // Small textbook key pair: n = 61 * 53, e = 17, d = 2753.
  task automatic test_rsa_pair();
    write_modulus(32'd3233);
    send_word(32'd65, 32'd17);
    send_word(32'd2790, 32'd2753);
    send_word(32'h8000_0000, 32'd17);
    send_word(32'd3233, 32'd2753);
  endtask

  task automatic test_random_words();
    logic [31:0] msg;
    logic [31:0] e;
    logic [31:0] m;
    int phase;
    int n;
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: m = $urandom();
        1: m = $urandom_range(2, 255);
        2: m = 32'hFFFF_FFFB;
        3: m = 32'h8000_0000;
        4: m = 32'd3;
        5: m = $urandom() | 32'h8000_0000;
        default: m = $urandom_range(2, 32'hFFFF_FFFF);
      endcase
      write_modulus(m);
      // Run the last phase without idling on either side.
      if (phase == 6) quiet = 1'b1;
      for (n = 0; n < WordsPerPhase; n++) begin
        case ($urandom_range(0, 9))
          0: msg = '0;
          1: msg = 32'hFFFF_FFFF;
          default: msg = $urandom();
        endcase
        case ($urandom_range(0, 7))
          0: e = $urandom_range(0, 15);
          1: e = 32'hFFFF_FFFF;
          default: e = $urandom();
        endcase
        send_word(msg, e);
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_modulus();
    test_degenerate_moduli();
    test_max_modulus();
    test_rsa_pair();
    test_random_words();

    drain_results();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d words over %0d modulus settings, checked %0d results.",
             words_sent, modulus_writes + 1, results_checked);
    $display("Moduli covered reset value, zero, one, small, power of two and all ones.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
